// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent check helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, masked while reset is asserted
`define CHK_HOLDS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// same clocking, written as a same-cycle implication
`define CHK_IMPLIES(label, cond, prop, msg) \
	`CHK_HOLDS(label, (cond) |-> (prop), msg)

`endif

// File: src/hcs_pkg.sv
// ----------------------------------------------------------------------------
// hcs_pkg
// types and constants of the hls colour shade unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hcs_pkg;

	localparam int CHAN_W           = 16;
	localparam int CHANNEL_BITS_DEF = 16;
	localparam int FIFO_DEPTH_DEF   = 4;

	localparam int FACTOR_W  = 16;
	localparam int FRAC_BITS = 12;
	localparam logic [FACTOR_W-1:0] FACTOR_RESET = 16'd4096;

	// hue in degrees, 8 fraction bits
	localparam int HUE_W = 17;
	localparam logic [HUE_W-1:0] DEG60  = 17'd15360;
	localparam logic [HUE_W-1:0] DEG120 = 17'd30720;
	localparam logic [HUE_W-1:0] DEG180 = 17'd46080;
	localparam logic [HUE_W-1:0] DEG240 = 17'd61440;
	localparam logic [HUE_W-1:0] DEG360 = 17'd92160;

	// divider geometry
	localparam int NUM_W = 32;
	localparam int DEN_W = 17;
	localparam int QUO_W = 16;

	// floor(2^32 / 15), exact since 15 divides 2^32 - 1
	localparam logic [31:0] RECIP15 = 32'd286331153;

	typedef struct packed {
		logic [CHAN_W-1:0] red_in;
		logic [CHAN_W-1:0] green_in;
		logic [CHAN_W-1:0] blue_in;
	} hcs_color_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red_out;
		logic [CHAN_W-1:0] green_out;
		logic [CHAN_W-1:0] blue_out;
	} hcs_result_t;

	// fields that ride alongside the divider
	typedef struct packed {
		logic [CHAN_W-1:0] light;
		logic              gray;
		logic              neg;
		logic [HUE_W-1:0]  base;
	} hcs_side_t;

	// classified colour, front to back
	typedef struct packed {
		hcs_side_t         side;
		logic [NUM_W-1:0]  num_s;
		logic [DEN_W-1:0]  den_s;
		logic [NUM_W-1:0]  num_h;
		logic [DEN_W-1:0]  den_h;
	} hcs_mid_t;

	typedef enum logic [1:0] {
		ZONE_RISE,
		ZONE_HIGH,
		ZONE_FALL,
		ZONE_LOW
	} hcs_zone_t;

endpackage

// File: src/hcs_front.sv
// ----------------------------------------------------------------------------
// hcs_front
// accepts colours, finds extremes, sector and divider operands
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcs_front #(
	parameter int CHANNEL_BITS = hcs_pkg::CHANNEL_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  hcs_pkg::hcs_color_t color,
	output logic               mid_valid,
	input  logic               mid_full,
	output hcs_pkg::hcs_mid_t  mid_item
);

	localparam int CW = hcs_pkg::CHAN_W;
	localparam int NW = hcs_pkg::NUM_W;
	localparam int HW = hcs_pkg::HUE_W;
	localparam logic [CW:0] CMAX = {1'b0, {CW{1'b1}}} >> (CW - CHANNEL_BITS);

	function automatic logic [CW-1:0] sat_in(logic [CW-1:0] v);
		if ({1'b0, v} > CMAX) begin
			return CMAX[CW-1:0];
		end
		return v;
	endfunction

	logic              ready;
	logic              v_s1;
	hcs_pkg::hcs_mid_t item_s1;
	hcs_pkg::hcs_mid_t item_d;

	logic [CW-1:0] r, g, b, mx, mn, d, first_c, second_c, mag;
	logic [CW:0]   sum;
	logic [HW-1:0] base;
	logic          neg;

	always_comb begin
		r   = sat_in(color.red_in);
		g   = sat_in(color.green_in);
		b   = sat_in(color.blue_in);
		mx  = (r > g) ? r : g;
		if (b > mx) begin
			mx = b;
		end
		mn  = (r < g) ? r : g;
		if (b < mn) begin
			mn = b;
		end
		sum = {1'b0, mx} + {1'b0, mn};
		d   = mx - mn;
		// red wins ties, then green
		if (r == mx) begin
			first_c  = g;
			second_c = b;
			base     = '0;
		end else if (g == mx) begin
			first_c  = b;
			second_c = r;
			base     = hcs_pkg::DEG120;
		end else begin
			first_c  = r;
			second_c = g;
			base     = hcs_pkg::DEG240;
		end
		neg = second_c > first_c;
		mag = neg ? (second_c - first_c) : (first_c - second_c);

		item_d.side.light = sum[CW:1];
		item_d.side.gray  = (mx == mn);
		item_d.side.neg   = neg;
		item_d.side.base  = base;
		// d * cmax as shift and subtract
		item_d.num_s = (NW'(d) << CHANNEL_BITS) - NW'(d);
		item_d.den_s = (sum <= CMAX) ? sum : ({CMAX[CW-1:0], 1'b0} - sum);
		// 15360 = 2^14 - 2^10
		item_d.num_h = (NW'(mag) << 14) - (NW'(mag) << 10);
		item_d.den_h = {1'b0, d};
	end

	assign ready     = !v_s1 || !mid_full;
	assign full      = !ready;
	assign mid_valid = v_s1;
	assign mid_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready) begin
			v_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && push) begin
			item_s1 <= item_d;
		end
	end

endmodule

// File: src/hcs_fifo.sv
// ----------------------------------------------------------------------------
// hcs_fifo
// short queue decoupling the front from the back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcs_fifo #(
	parameter int DEPTH = hcs_pkg::FIFO_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  hcs_pkg::hcs_mid_t wr_item,
	output logic              full,
	input  logic              rd,
	output hcs_pkg::hcs_mid_t rd_item,
	output logic              empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CNW = $clog2(DEPTH + 1);

	hcs_pkg::hcs_mid_t mem_q [DEPTH];
	logic [AW-1:0]     wp_q, rp_q;
	logic [CNW-1:0]    cnt_q;
	logic              do_wr, do_rd;

	assign full    = (cnt_q == CNW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_item = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_item;
		end
	end

endmodule

// File: src/hcs_div.sv
// ----------------------------------------------------------------------------
// hcs_div
// two-lane pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcs_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  hcs_pkg::hcs_mid_t       in_item,
	output logic                    out_valid,
	output logic [hcs_pkg::QUO_W-1:0] out_qs,
	output logic [hcs_pkg::QUO_W-1:0] out_qh,
	output hcs_pkg::hcs_side_t      out_side
);

	localparam int QB  = hcs_pkg::QUO_W;
	localparam int NW  = hcs_pkg::NUM_W;
	localparam int NW1 = NW + 1;
	localparam int DW  = hcs_pkg::DEN_W;

	logic               v_s    [QB];
	logic [NW-1:0]      rs_s   [QB];
	logic [NW-1:0]      rh_s   [QB];
	logic [DW-1:0]      ds_s   [QB];
	logic [DW-1:0]      dh_s   [QB];
	logic [QB-1:0]      qs_s   [QB];
	logic [QB-1:0]      qh_s   [QB];
	hcs_pkg::hcs_side_t side_s [QB];

	for (genvar k = 0; k < QB; k++) begin : g_stage
		localparam int SH = QB - 1 - k;

		logic               v_in;
		logic [NW-1:0]      rs_in, rh_in;
		logic [DW-1:0]      ds_in, dh_in;
		logic [QB-1:0]      qs_in, qh_in;
		hcs_pkg::hcs_side_t side_in;
		logic [NW:0]        ts, th;
		logic               ges, geh;

		if (k == 0) begin : g_first
			assign v_in    = in_valid;
			assign rs_in   = in_item.num_s;
			assign rh_in   = in_item.num_h;
			assign ds_in   = in_item.den_s;
			assign dh_in   = in_item.den_h;
			assign qs_in   = '0;
			assign qh_in   = '0;
			assign side_in = in_item.side;
		end else begin : g_next
			assign v_in    = v_s[k-1];
			assign rs_in   = rs_s[k-1];
			assign rh_in   = rh_s[k-1];
			assign ds_in   = ds_s[k-1];
			assign dh_in   = dh_s[k-1];
			assign qs_in   = qs_s[k-1];
			assign qh_in   = qh_s[k-1];
			assign side_in = side_s[k-1];
		end

		// trial subtrahend: divisor aligned to this quotient bit
		assign ts  = NW1'(ds_in) << SH;
		assign th  = NW1'(dh_in) << SH;
		assign ges = {1'b0, rs_in} >= ts;
		assign geh = {1'b0, rh_in} >= th;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rs_s[k]   <= ges ? (rs_in - ts[NW-1:0]) : rs_in;
				rh_s[k]   <= geh ? (rh_in - th[NW-1:0]) : rh_in;
				ds_s[k]   <= ds_in;
				dh_s[k]   <= dh_in;
				qs_s[k]   <= qs_in | (QB'(ges) << SH);
				qh_s[k]   <= qh_in | (QB'(geh) << SH);
				side_s[k] <= side_in;
			end
		end
	end

	assign out_valid = v_s[QB-1];
	assign out_qs    = qs_s[QB-1];
	assign out_qh    = qh_s[QB-1];
	assign out_side  = side_s[QB-1];

endmodule

// File: src/hcs_back.sv
// ----------------------------------------------------------------------------
// hcs_back
// divides, scales lightness and saturation, rebuilds rgb, holds the result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcs_back #(
	parameter int CHANNEL_BITS = hcs_pkg::CHANNEL_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [hcs_pkg::FACTOR_W-1:0]  factor,
	input  logic                          mid_empty,
	output logic                          mid_rd,
	input  hcs_pkg::hcs_mid_t             mid_item,
	output logic                          empty,
	input  logic                          pop,
	output hcs_pkg::hcs_result_t          result
);

	localparam int CW  = hcs_pkg::CHAN_W;
	localparam int HW  = hcs_pkg::HUE_W;
	localparam int QB  = hcs_pkg::QUO_W;
	localparam int FB  = hcs_pkg::FRAC_BITS;
	localparam int PW  = 2 * CW;
	localparam int SPW = CW + 15;
	localparam int YW  = SPW - 10;
	localparam int QW  = YW - 3;
	localparam int RW  = YW + 32;
	localparam logic [CW:0] CMAX = {1'b0, {CW{1'b1}}} >> (CW - CHANNEL_BITS);

	function automatic logic [CW-1:0] clamp_scaled(logic [PW-1:0] v);
		if (v[PW-1:FB] > (PW-FB)'(CMAX)) begin
			return CMAX[CW-1:0];
		end
		return v[FB+CW-1:FB];
	endfunction

	function automatic logic [CW-1:0] sat_out(logic [CW+1:0] v);
		if (v > {1'b0, CMAX}) begin
			return CMAX[CW-1:0];
		end
		return v[CW-1:0];
	endfunction

	logic en;

	// divider
	logic               dv;
	logic [QB-1:0]      dqs, dqh;
	hcs_pkg::hcs_side_t dside;

	// stage registers
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic [CW-1:0] light_s1, sat_s1;
	logic [HW-1:0] hue_s1, hue_s2, hue_s3, hue_s4, hue_s5, hue_s6, hue_s7;
	logic [PW-1:0] lp_s2, sp_s2;
	logic [CW-1:0] l2_s3, s2_s3, l2_s4, s2_s4, l2_s5, s2_s5, l2_s6, s2_s6;
	logic [CW-1:0] l2_s7, l2_s8, l2_s9;
	logic          zero_s4, zero_s5, zero_s6, zero_s7, zero_s8, zero_s9;
	logic [PW-1:0] prod_s4, prod_s5;
	logic [CW:0]   q0_s5;
	logic [CW-1:0] q_s6;
	logic [CW:0]   m1_s7, m2_s7, m1_s8, m2_s8, m1_s9, m2_s9;
	hcs_pkg::hcs_zone_t zone_s8 [3];
	hcs_pkg::hcs_zone_t zone_s9 [3];
	logic [SPW-1:0] sp_s8 [3];
	logic [YW-1:0]  y_s9  [3];
	logic [QW-1:0]  q0_s9 [3];

	logic                 out_v_q;
	hcs_pkg::hcs_result_t out_q;

	// everything behind the queue moves together, held while a result waits
	assign en     = !out_v_q || pop;
	assign mid_rd = en && !mid_empty;

	hcs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (!mid_empty),
		.in_item   (mid_item),
		.out_valid (dv),
		.out_qs    (dqs),
		.out_qh    (dqh),
		.out_side  (dside)
	);

	// hue from sector base and signed quotient
	logic [HW-1:0] qh_e, hue_d;
	assign qh_e = HW'(dqh);

	always_comb begin
		if (dside.gray) begin
			hue_d = '0;
		end else if (!dside.neg) begin
			hue_d = dside.base + qh_e;
		end else if (qh_e > dside.base) begin
			hue_d = dside.base + hcs_pkg::DEG360 - qh_e;
		end else begin
			hue_d = dside.base - qh_e;
		end
	end

	// divide by cmax: estimate then one-step correction
	logic [PW:0]   est_sum;
	logic [PW+1:0] qm, rem6;
	logic [CW:0]   qc;

	always_comb begin
		est_sum = {1'b0, prod_s4} + ((PW+1)'(prod_s4) >> CHANNEL_BITS) + 1'b1;
		qm      = ((PW+2)'(q0_s5) << CHANNEL_BITS) - (PW+2)'(q0_s5);
		rem6    = (PW+2)'(prod_s5) - qm;
		if (rem6[PW+1]) begin
			qc = q0_s5 - 1'b1;
		end else if (rem6 >= (PW+2)'(CMAX)) begin
			qc = q0_s5 + 1'b1;
		end else begin
			qc = q0_s5;
		end
	end

	// m1 and m2
	logic [CW+1:0] m2_d, m1_d;

	always_comb begin
		if ({l2_s6, 1'b0} > CMAX) begin
			m2_d = (CW+2)'(l2_s6) + (CW+2)'(s2_s6) - (CW+2)'(q_s6);
		end else begin
			m2_d = (CW+2)'(l2_s6) + (CW+2)'(q_s6);
		end
		m1_d = {1'b0, l2_s6, 1'b0} - m2_d;
	end

	// hue position of each channel and its ramp product
	logic [HW-1:0]      pos   [3];
	logic [13:0]        tpos  [3];
	hcs_pkg::hcs_zone_t zone_d [3];
	logic [SPW-1:0]     sp_d  [3];
	logic [CW:0]        span;

	always_comb begin
		span   = m2_s7 - m1_s7;
		pos[0] = (hue_s7 >= hcs_pkg::DEG240) ? (hue_s7 - hcs_pkg::DEG240)
			: (hue_s7 + hcs_pkg::DEG120);
		pos[1] = hue_s7;
		pos[2] = (hue_s7 >= hcs_pkg::DEG120) ? (hue_s7 - hcs_pkg::DEG120)
			: (hue_s7 + hcs_pkg::DEG240);
		for (int c = 0; c < 3; c++) begin
			if (pos[c] < hcs_pkg::DEG60) begin
				zone_d[c] = hcs_pkg::ZONE_RISE;
				tpos[c]   = pos[c][13:0];
			end else if (pos[c] < hcs_pkg::DEG180) begin
				zone_d[c] = hcs_pkg::ZONE_HIGH;
				tpos[c]   = '0;
			end else if (pos[c] < hcs_pkg::DEG240) begin
				zone_d[c] = hcs_pkg::ZONE_FALL;
				tpos[c]   = 14'(hcs_pkg::DEG240 - pos[c]);
			end else begin
				zone_d[c] = hcs_pkg::ZONE_LOW;
				tpos[c]   = '0;
			end
			sp_d[c] = SPW'(span) * SPW'(tpos[c]);
		end
	end

	// divide by 15360: drop 10 bits, then reciprocal of 15
	logic [YW-1:0] y_d  [3];
	logic [RW-1:0] rp_d [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			y_d[c]  = sp_s8[c][SPW-1:10];
			rp_d[c] = RW'(y_d[c]) * RW'(hcs_pkg::RECIP15);
		end
	end

	// final channel values
	logic [CW-1:0] chan_d [3];
	logic [YW-1:0] rr     [3];
	logic [QW-1:0] qq     [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			rr[c] = y_s9[c] - ((YW'(q0_s9[c]) << 4) - YW'(q0_s9[c]));
			qq[c] = (rr[c] >= YW'(15)) ? (q0_s9[c] + 1'b1) : q0_s9[c];
			case (zone_s9[c])
				hcs_pkg::ZONE_RISE,
				hcs_pkg::ZONE_FALL: chan_d[c] = sat_out((CW+2)'(m1_s9) + (CW+2)'(qq[c]));
				hcs_pkg::ZONE_HIGH: chan_d[c] = sat_out((CW+2)'(m2_s9));
				hcs_pkg::ZONE_LOW:  chan_d[c] = sat_out((CW+2)'(m1_s9));
				default:            chan_d[c] = sat_out((CW+2)'(m1_s9));
			endcase
			if (zero_s9) begin
				chan_d[c] = l2_s9;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_s6    <= 1'b0;
			v_s7    <= 1'b0;
			v_s8    <= 1'b0;
			v_s9    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_s1    <= dv;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			v_s5    <= v_s4;
			v_s6    <= v_s5;
			v_s7    <= v_s6;
			v_s8    <= v_s7;
			v_s9    <= v_s8;
			out_v_q <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			light_s1 <= dside.light;
			sat_s1   <= dside.gray ? '0 : CW'(dqs);
			hue_s1   <= hue_d;

			lp_s2  <= PW'(light_s1) * PW'(factor);
			sp_s2  <= PW'(sat_s1) * PW'(factor);
			hue_s2 <= hue_s1;

			l2_s3  <= clamp_scaled(lp_s2);
			s2_s3  <= clamp_scaled(sp_s2);
			hue_s3 <= hue_s2;

			prod_s4 <= PW'(l2_s3) * PW'(s2_s3);
			l2_s4   <= l2_s3;
			s2_s4   <= s2_s3;
			zero_s4 <= (s2_s3 == '0);
			hue_s4  <= hue_s3;

			q0_s5   <= est_sum[CHANNEL_BITS +: CW+1];
			prod_s5 <= prod_s4;
			l2_s5   <= l2_s4;
			s2_s5   <= s2_s4;
			zero_s5 <= zero_s4;
			hue_s5  <= hue_s4;

			q_s6    <= qc[CW-1:0];
			l2_s6   <= l2_s5;
			s2_s6   <= s2_s5;
			zero_s6 <= zero_s5;
			hue_s6  <= hue_s5;

			m2_s7   <= m2_d[CW:0];
			m1_s7   <= m1_d[CW:0];
			l2_s7   <= l2_s6;
			zero_s7 <= zero_s6;
			hue_s7  <= hue_s6;

			for (int c = 0; c < 3; c++) begin
				zone_s8[c] <= zone_d[c];
				sp_s8[c]   <= sp_d[c];
				zone_s9[c] <= zone_s8[c];
				y_s9[c]    <= y_d[c];
				q0_s9[c]   <= rp_d[c][32 +: QW];
			end
			m1_s8   <= m1_s7;
			m2_s8   <= m2_s7;
			l2_s8   <= l2_s7;
			zero_s8 <= zero_s7;

			m1_s9   <= m1_s8;
			m2_s9   <= m2_s8;
			l2_s9   <= l2_s8;
			zero_s9 <= zero_s8;

			out_q.red_out   <= chan_d[0];
			out_q.green_out <= chan_d[1];
			out_q.blue_out  <= chan_d[2];
		end
	end

	assign empty  = !out_v_q;
	assign result = out_q;

endmodule

// File: src/hls_color_shade_unit.sv
// ----------------------------------------------------------------------------
// hls_color_shade_unit
// shades an rgb colour through hue, lightness and saturation
// ----------------------------------------------------------------------------
//
// channel   handshake            beat
// -------   ------------------   ------------------------------------
// input     push / full          color: red_in, green_in, blue_in
// result    pop / empty          result: red_out, green_out, blue_out
// config    cfg_valid/cfg_ready  cfg_data: shade factor, q4.12
//
// one colour per cycle sustained while results are popped; a pushed colour
// passes the front register, the queue, the 16-stage pipelined divider,
// nine back stages and the result register
// reset clears all valid state and loads the factor with 1.0
// a result not popped freezes the back pipeline; the queue and the front
// register keep taking colours until they fill, then full rises
// cfg_ready is always high
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module hls_color_shade_unit #(
	parameter int CHANNEL_BITS = hcs_pkg::CHANNEL_BITS_DEF,
	parameter int FIFO_DEPTH   = hcs_pkg::FIFO_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// colour input
	input  logic                         push,
	output logic                         full,
	input  hcs_pkg::hcs_color_t          color,
	// shaded result
	output logic                         empty,
	input  logic                         pop,
	output hcs_pkg::hcs_result_t         result,
	// shade factor write
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [hcs_pkg::FACTOR_W-1:0] cfg_data
);

	localparam int CW = hcs_pkg::CHAN_W;
	localparam logic [CW:0] CMAX = {1'b0, {CW{1'b1}}} >> (CW - CHANNEL_BITS);

	// shade factor register
	logic [hcs_pkg::FACTOR_W-1:0] shade_factor_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shade_factor_q <= hcs_pkg::FACTOR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			shade_factor_q <= cfg_data;
		end
	end

	// front to queue
	logic              mid_wr;
	logic              mid_full;
	hcs_pkg::hcs_mid_t mid_wr_item;

	// queue to back
	logic              mid_rd;
	logic              mid_empty;
	hcs_pkg::hcs_mid_t mid_rd_item;

	// extremes, sector and divider operands, one register stage
	hcs_front #(
		.CHANNEL_BITS (CHANNEL_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.color     (color),
		.mid_valid (mid_wr),
		.mid_full  (mid_full),
		.mid_item  (mid_wr_item)
	);

	// slack between front and back
	hcs_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (mid_wr),
		.wr_item (mid_wr_item),
		.full    (mid_full),
		.rd      (mid_rd),
		.rd_item (mid_rd_item),
		.empty   (mid_empty)
	);

	// divider, scaling, rgb rebuild and result register
	hcs_back #(
		.CHANNEL_BITS (CHANNEL_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.factor    (shade_factor_q),
		.mid_empty (mid_empty),
		.mid_rd    (mid_rd),
		.mid_item  (mid_rd_item),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	// all three result channels within full scale
	logic res_in_range;

	assign res_in_range = ({1'b0, result.red_out} <= CMAX)
		&& ({1'b0, result.green_out} <= CMAX)
		&& ({1'b0, result.blue_out} <= CMAX);

	// the front keeps offering a beat while the queue is full
	`CHK_IMPLIES(a_mid_hold, (mid_wr && mid_full), ##1 mid_wr, "front dropped a beat at a full queue")

	// a waiting result that is not popped stalls every stage behind the queue
	`CHK_IMPLIES(a_stall_no_read, (!empty && !pop), !mid_rd, "queue read while result stalled")

	// every shaded channel stays within full scale
	`CHK_IMPLIES(a_range, !empty, res_in_range, "result channel above full scale")

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the hls colour shade unit: random and directed
// colours under several shade factors, results checked against a predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	localparam int CMAX = 65535;
	localparam int LATENCY = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	hcs_pkg::hcs_color_t color = '0;
	logic empty;
	logic pop = 1'b0;
	hcs_pkg::hcs_result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [hcs_pkg::FACTOR_W-1:0] cfg_data = '0;

	// predictor copy of the factor register
	logic [hcs_pkg::FACTOR_W-1:0] factor = hcs_pkg::FACTOR_RESET;

	hcs_pkg::hcs_color_t colors_pending[$];
	hcs_pkg::hcs_result_t shades_due[$];

	int n_fail = 0;
	int n_checked = 0;
	int n_sent = 0;
	bit calm = 1'b0;     // no idling on either side while set
	bit hold = 1'b0;     // sender paused

	hls_color_shade_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .color(color),
		.empty(empty), .pop(pop), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// channel at one hue position of the shaded colour
	function automatic longint shade_at(longint p, longint m1, longint m2);
		longint v;
		if (p >= 92160) p -= 92160;
		if (p < 0) p += 92160;
		if (p < 15360) v = m1 + (m2 - m1) * p / 15360;
		else if (p < 46080) v = m2;
		else if (p < 61440) v = m1 + (m2 - m1) * (61440 - p) / 15360;
		else v = m1;
		return v > CMAX ? CMAX : v;
	endfunction

	function automatic hcs_pkg::hcs_result_t shade_color(hcs_pkg::hcs_color_t c,
		logic [hcs_pkg::FACTOR_W-1:0] f);
		longint r, g, b, mx, mn, sum, lig, sat, hue, d, l2, s2, m1, m2;
		hcs_pkg::hcs_result_t o;
		r = c.red_in; g = c.green_in; b = c.blue_in;
		mx = r > g ? r : g; if (b > mx) mx = b;
		mn = r < g ? r : g; if (b < mn) mn = b;
		sum = mx + mn;
		lig = sum >> 1;
		sat = 0; hue = 0;
		if (mx != mn) begin
			d = mx - mn;
			// truncating signed division matches the hue quotients
			if (sum <= CMAX) sat = d * CMAX / sum;
			else sat = d * CMAX / (2 * CMAX - sum);
			if (r == mx) hue = 15360 * (g - b) / d;
			else if (g == mx) hue = 30720 + 15360 * (b - r) / d;
			else hue = 61440 + 15360 * (r - g) / d;
			if (hue < 0) hue += 92160;
		end
		l2 = (lig * f) >> 12; if (l2 > CMAX) l2 = CMAX;
		s2 = (sat * f) >> 12; if (s2 > CMAX) s2 = CMAX;
		if (s2 == 0) begin
			o.red_out = l2[15:0]; o.green_out = l2[15:0]; o.blue_out = l2[15:0];
			return o;
		end
		if (2 * l2 <= CMAX) m2 = l2 * (CMAX + s2) / CMAX;
		else m2 = l2 + s2 - (l2 * s2 / CMAX);
		m1 = 2 * l2 - m2;
		o.red_out = 16'(shade_at(hue + 30720, m1, m2));
		o.green_out = 16'(shade_at(hue, m1, m2));
		o.blue_out = 16'(shade_at(hue - 30720, m1, m2));
		return o;
	endfunction

	function automatic logic [15:0] rand_chan();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(0, 255));
			3: return 16'hFFFF - 16'($urandom_range(0, 255));
			default: return 16'($urandom);
		endcase
	endfunction

	// driver: one colour beat offered at a time, changes at falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (colors_pending.size() != 0 && !hold && (calm || $urandom_range(0, 99) >= 33)) begin
				push <= 1'b1;
				color <= colors_pending[0];
			end else begin
				push <= 1'b0;
			end
			pop <= calm || $urandom_range(0, 99) >= 33;
		end
	end

	// predictor runs on accepted colours; monitor checks popped results
	always @(posedge clk) begin
		if (arst_n && push && !full) begin
			shades_due.push_back(shade_color(color, factor));
			void'(colors_pending.pop_front());
			n_sent++;
		end
		if (arst_n && pop && !empty) begin
			if (shades_due.size() == 0) begin
				$display("%0t: result beat with nothing due, actual %h", $time, result);
				n_fail++;
			end else begin
				if (result.red_out !== shades_due[0].red_out)
					$display("%0t: red mismatch, expected %h actual %h", $time,
						shades_due[0].red_out, result.red_out);
				if (result.green_out !== shades_due[0].green_out)
					$display("%0t: green mismatch, expected %h actual %h", $time,
						shades_due[0].green_out, result.green_out);
				if (result.blue_out !== shades_due[0].blue_out)
					$display("%0t: blue mismatch, expected %h actual %h", $time,
						shades_due[0].blue_out, result.blue_out);
				if (result !== shades_due[0]) n_fail++;
				void'(shades_due.pop_front());
				n_checked++;
			end
		end
		if (arst_n && cfg_valid && cfg_ready)
			factor <= cfg_data;
	end

	task automatic drain();
		wait (colors_pending.size() == 0 && !push);
		wait (shades_due.size() == 0);
		repeat (LATENCY) @(posedge clk);
	endtask

	// factor write while the unit is idle
	task automatic write_factor(logic [hcs_pkg::FACTOR_W-1:0] f);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= f;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_color(logic [15:0] r, logic [15:0] g, logic [15:0] b);
		hcs_pkg::hcs_color_t c;
		c.red_in = r; c.green_in = g; c.blue_in = b;
		colors_pending.push_back(c);
	endtask

	task automatic queue_random(int n);
		int k;
		for (k = 0; k < n; k++) queue_color(rand_chan(), rand_chan(), rand_chan());
	endtask

	initial begin
		logic [hcs_pkg::FACTOR_W-1:0] factors[6];
		int k;
		factors = '{16'd4096, 16'd0, 16'hFFFF, 16'd2048, 16'd6144, 16'd1};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: extremes, grays, each sextant, ties
		queue_color(16'h0000, 16'h0000, 16'h0000);
		queue_color(16'hFFFF, 16'hFFFF, 16'hFFFF);
		queue_color(16'h8000, 16'h8000, 16'h8000);
		queue_color(16'hFFFF, 16'h0000, 16'h0000);
		queue_color(16'h0000, 16'hFFFF, 16'h0000);
		queue_color(16'h0000, 16'h0000, 16'hFFFF);
		queue_color(16'hFFFF, 16'hFFFF, 16'h0000);
		queue_color(16'h0000, 16'hFFFF, 16'hFFFF);
		queue_color(16'hFFFF, 16'h0000, 16'hFFFF);
		queue_color(16'hFFFF, 16'h8000, 16'h0000);
		queue_color(16'hFFFF, 16'h0000, 16'h8000);
		queue_color(16'h1234, 16'hABCD, 16'h5555);
		queue_color(16'hAAAA, 16'h5555, 16'hFFFF);
		queue_color(16'hFFFF, 16'hFFFE, 16'h0001);
		queue_color(16'h0001, 16'h0000, 16'h0000);
		drain();

		// random colours under each factor, reset value first and last
		for (k = 0; k < 7; k++) begin
			write_factor(k == 6 ? hcs_pkg::FACTOR_RESET : factors[k % 6]);
			calm = (k == 2);
			queue_random(k == 0 ? 15 : 150);
			drain();
		end

		// random factors, with a pause until everything is back
		for (k = 0; k < 4; k++) begin
			write_factor(16'($urandom));
			queue_random(60);
			wait (colors_pending.size() <= 30);
			hold = 1'b1;
			drain_results_only();
			hold = 1'b0;
			drain();
		end
		calm = 1'b0;

		$display("covered %0d colours over directed and random sets, %0d results checked",
			n_sent, n_checked);
		$display("factors swept: 1.0, 0, max, 0.5, 1.5, minimum step and random");
		if (n_fail == 0 && shades_due.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	task automatic drain_results_only();
		repeat (5) @(posedge clk);
		wait (shades_due.size() == 0);
	endtask

	initial begin
		#5ms;
		$display("timeout after %0d results", n_checked);
		$display("Test completed with failures");
		$finish;
	end

endmodule

// File: hls_color_shade_unit.f
+incdir+src
src/hcs_pkg.sv
src/hcs_front.sv
src/hcs_fifo.sv
src/hcs_div.sv
src/hcs_back.sv
src/hls_color_shade_unit.sv
verif/tb.sv
